### rtl/cpcd_pkg.sv
// Shared types and constants for the circle pair collision detector.
// No dependencies; imported by the controller, datapath and top level.
package cpcd_pkg;

  localparam int POS_W     = 16;
  localparam int RAD_W     = 12;
  localparam int OBJ_IDX_W = 5;
  localparam int MASK_W    = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } cpcd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // store one accepted object
    logic start_obj;  // clear hit mask, restart target counter
    logic issue_j;    // read next target into the pair pipeline
    logic next_obj;   // advance to the next tester object
    logic end_set;    // final result taken: clear count and overflow
  } cpcd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic j_done;     // target being issued is the last loaded object
    logic last_obj;   // tester is the last loaded object
    logic pipe_busy;  // pair pipeline still holds tests in flight
  } cpcd_sts_t;

endpackage

### rtl/cpcd_ctrl.sv
// Sequencing state machine for the circle pair collision detector.
// Depends on cpcd_pkg for the state, command and status types.
module cpcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_in,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cpcd_pkg::cpcd_sts_t sts,
  output cpcd_pkg::cpcd_cmd_t cmd
);
  import cpcd_pkg::*;

  cpcd_state_t state_r;
  cpcd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_in) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sts.j_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          state_nxt = sts.last_obj ? ST_LOAD : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_FETCH: begin
        cmd.start_obj = 1'b1;
      end
      ST_SWEEP: begin
        cmd.issue_j = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.next_obj = !out_stall && !sts.last_obj;
        cmd.end_set  = !out_stall && sts.last_obj;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/cpcd_dp.sv
// Object store, counters and pair test pipeline of the collision detector.
// Depends on cpcd_pkg for field widths and the command/status structs.
module cpcd_dp #(
  parameter int MAX_OBJECTS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic [cpcd_pkg::POS_W-1:0]       in_pos_x,
  input  logic [cpcd_pkg::POS_W-1:0]       in_pos_y,
  input  logic [cpcd_pkg::RAD_W-1:0]       in_radius,
  input  logic                             in_collidable,
  input  cpcd_pkg::cpcd_cmd_t              cmd,
  output cpcd_pkg::cpcd_sts_t              sts,
  output logic [cpcd_pkg::OBJ_IDX_W-1:0]   out_object_index,
  output logic [cpcd_pkg::MASK_W-1:0]      out_hit_mask,
  output logic                             out_overflow,
  output logic                             out_last_out
);
  import cpcd_pkg::*;

  localparam int IDX_W   = $clog2(MAX_OBJECTS);
  localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
  localparam int ENTRY_W = 2 * POS_W + RAD_W + 1;
  localparam int DIST_W  = 2 * POS_W + 1;
  localparam int RS_W    = RAD_W + 1;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [RAD_W-1:0] r;
    logic             coll;
  } obj_t;

  logic [ENTRY_W-1:0] mem [MAX_OBJECTS];

  logic             filter_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic [CNT_W-1:0] last_pos;

  obj_t             rd_a_r;
  obj_t             rd_b_r;

  // pipeline: read -> differences -> squares -> compare
  logic             v0_r;
  logic             v1_r;
  logic             v2_r;
  logic [IDX_W-1:0] j0_r;
  logic [IDX_W-1:0] j1_r;
  logic [IDX_W-1:0] j2_r;
  logic             elig1_r;
  logic             elig2_r;
  logic [POS_W-1:0] dx_r;
  logic [POS_W-1:0] dy_r;
  logic [RS_W-1:0]  rs_r;
  logic [2*POS_W-1:0] dx2_r;
  logic [2*POS_W-1:0] dy2_r;
  logic [2*RS_W-1:0]  rs2_r;
  logic [MASK_W-1:0]  mask_r;

  logic [IDX_W+OBJ_IDX_W-1:0] i_ext;
  logic [IDX_W+OBJ_IDX_W:0]   j_ext;
  logic                       part_a;
  logic                       part_b;
  logic                       elig0;
  logic [DIST_W-1:0]          dist2;
  logic                       hit;

  assign last_pos = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r <= 1'b0;
    end else if (cfg_wr_en) begin
      filter_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNT_W'(MAX_OBJECTS))) begin
      mem[count_r[IDX_W-1:0]] <= {in_pos_x, in_pos_y, in_radius, in_collidable};
    end
    rd_a_r <= obj_t'(mem[i_r]);
    rd_b_r <= obj_t'(mem[j_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      if (cmd.load) begin
        if (count_r < CNT_W'(MAX_OBJECTS)) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.start_obj) begin
        j_r <= '0;
      end else if (cmd.issue_j) begin
        j_r <= j_r + IDX_W'(1);
      end
      if (cmd.next_obj) begin
        i_r <= i_r + IDX_W'(1);
      end
      if (cmd.end_set) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        i_r     <= '0;
      end
    end
  end

  // Stage 1: eligibility, absolute differences and radius sum
  assign part_a = !filter_r || rd_a_r.coll;
  assign part_b = !filter_r || rd_b_r.coll;
  assign j_ext  = {{(OBJ_IDX_W + 1){1'b0}}, j0_r};
  assign elig0  = (j0_r != i_r) && part_a && part_b &&
                  (j_ext < (IDX_W + OBJ_IDX_W + 1)'(MASK_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue_j;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    j0_r    <= j_r;
    j1_r    <= j0_r;
    j2_r    <= j1_r;
    elig1_r <= elig0;
    elig2_r <= elig1_r;
    dx_r    <= (rd_a_r.x >= rd_b_r.x) ? rd_a_r.x - rd_b_r.x : rd_b_r.x - rd_a_r.x;
    dy_r    <= (rd_a_r.y >= rd_b_r.y) ? rd_a_r.y - rd_b_r.y : rd_b_r.y - rd_a_r.y;
    rs_r    <= {1'b0, rd_a_r.r} + {1'b0, rd_b_r.r};
    // Stage 2: squares
    dx2_r   <= dx_r * dx_r;
    dy2_r   <= dy_r * dy_r;
    rs2_r   <= rs_r * rs_r;
  end

  // Stage 3: compare and set the mask bit
  assign dist2 = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign hit   = dist2 < DIST_W'(rs2_r);

  always_ff @(posedge clk) begin
    if (cmd.start_obj) begin
      mask_r <= '0;
    end else if (v2_r && elig2_r && hit) begin
      mask_r[j2_r[OBJ_IDX_W-1 < IDX_W-1 ? OBJ_IDX_W-1 : IDX_W-1:0]] <= 1'b1;
    end
  end

  assign sts.j_done    = ({1'b0, j_r} == (IDX_W + 1)'(last_pos));
  assign sts.last_obj  = ({1'b0, i_r} == (IDX_W + 1)'(last_pos));
  assign sts.pipe_busy = v0_r || v1_r || v2_r;

  assign i_ext            = {{OBJ_IDX_W{1'b0}}, i_r};
  assign out_object_index = i_ext[OBJ_IDX_W-1:0];
  assign out_hit_mask     = mask_r;
  assign out_overflow     = ovf_r;
  assign out_last_out     = sts.last_obj;

endmodule

### rtl/circle_pair_collision_detect.sv
// Circle pair collision detector, top level. Loading takes one object per cycle.
// After the closing object, each object i in turn takes one store read, n pair tests
// (n loaded objects) through the single distance unit, a pipeline drain and the
// result transaction; loading resumes only after the last object's result.
// Synchronous active low reset clears the controller, object count, overflow flag
// and filter; the store is not cleared.
module circle_pair_collision_detect #(
  parameter int MAX_OBJECTS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel: one circle per transaction
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cpcd_pkg::POS_W-1:0]     in_pos_x,
  input  logic [cpcd_pkg::POS_W-1:0]     in_pos_y,
  input  logic [cpcd_pkg::RAD_W-1:0]     in_radius,
  input  logic                           in_collidable,
  input  logic                           in_last_in,
  // result channel: one hit mask per loaded object
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cpcd_pkg::OBJ_IDX_W-1:0] out_object_index,
  output logic [cpcd_pkg::MASK_W-1:0]    out_hit_mask,
  output logic                           out_overflow,
  output logic                           out_last_out,
  // filter_by_kind register
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data
);
  import cpcd_pkg::*;

  cpcd_cmd_t cmd;
  cpcd_sts_t sts;

  // The controller walks the set: load objects until the closing transaction,
  // then for each tester fetch it, sweep every loaded target through the pair
  // pipeline, drain the pipeline and hold the result until it is taken.
  cpcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_last_in (in_last_in),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath keeps the object store (two read ports: tester and target),
  // the count and overflow flag, and the difference/square/compare pipeline
  // that builds the hit mask one target per cycle. Result fields come straight
  // from its registers, so they hold steady while the result is stalled.
  cpcd_dp #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_radius        (in_radius),
    .in_collidable    (in_collidable),
    .cmd              (cmd),
    .sts              (sts),
    .out_object_index (out_object_index),
    .out_hit_mask     (out_hit_mask),
    .out_overflow     (out_overflow),
    .out_last_out     (out_last_out)
  );

`ifndef SYNTHESIS
  // Loading and result delivery never overlap
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall && out_valid))
    else $error("input transaction taken while a result is offered");

  // A result is only offered once every pair test has retired
  a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sts.pipe_busy)
    else $error("result offered with pair tests still in flight");

  // Taking the final result of a set reopens the input channel
  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_out) |=> (!in_stall && !out_valid))
    else $error("input not reopened after final result");

  // Pair tests are only issued while input is closed
  a_sweep_excl_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_j |-> (in_stall && !cmd.load))
    else $error("pair sweep overlaps object loading");
`endif

endmodule
